// File: hw/rtl/collision_safe_distance_core_macros.svh
// ----------------------------------------------------------------------------
// Collision safe distance core: assertion macros
// Concurrent checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef COLLISION_SAFE_DISTANCE_CORE_MACROS_SVH
`define COLLISION_SAFE_DISTANCE_CORE_MACROS_SVH

// same-cycle implication
`define CSD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/csd_pkg.sv
// ----------------------------------------------------------------------------
// Collision safe distance package
// Shared types, case codes, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package csd_pkg;

  localparam int DEN_W = 14;
  localparam int REG_IDX_W = 1;
  localparam int CFG_DATA_W = 15;

  localparam logic [REG_IDX_W-1:0] REG_REACTION = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_GAP  = 1'b1;

  localparam logic [11:0] RT_RESET = 12'd563;
  localparam logic [14:0] MG_RESET = 15'd512;

  localparam logic [2:0] CODE_ONCOMING = 3'd0;
  localparam logic [2:0] CODE_REACT    = 3'd1;
  localparam logic [2:0] CODE_REAR     = 3'd2;
  localparam logic [2:0] CODE_FRONT    = 3'd3;
  localparam logic [2:0] CODE_AWAY     = 3'd4;
  localparam logic [2:0] CODE_NOEQ     = 3'd5;

  localparam logic signed [23:0] DIST_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] DIST_MIN = 24'sh800000;

  typedef struct packed {
    logic signed [15:0] dv;
    logic signed [14:0] v1;
    logic signed [12:0] a0;
    logic signed [12:0] a1;
    logic               v0_neg;
    logic               a0_pos;
    logic               a0_zero;
    logic               a1_zero;
    logic               den_zero;
  } side_t;

endpackage

`default_nettype wire

// File: hw/rtl/csd_delay.sv
// ----------------------------------------------------------------------------
// Collision safe distance delay line
// Carries valid and side data alongside the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_delay #(
  parameter int W = 62,
  parameter int DEPTH = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  output logic [W-1:0] out_data
);

  logic         vld [DEPTH];
  logic [W-1:0] dat [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat[0] <= in_data;
    end
  end

  for (genvar k = 1; k < DEPTH; k++) begin : g_tap
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dat[k] <= dat[k-1];
      end
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_data  = dat[DEPTH-1];

endmodule

`default_nettype wire

// File: hw/rtl/csd_div.sv
// ----------------------------------------------------------------------------
// Collision safe distance divider
// Pipelined restoring divider, one quotient bit per stage, floor rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_div #(
  parameter int DW = 29
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [DW:0]             num,
  input  logic signed [csd_pkg::DEN_W-1:0] den,
  output logic signed [DW:0]             q
);

  import csd_pkg::*;

  localparam int NW = DW + 1;
  localparam int MW = DEN_W - 1;

  logic [MW-1:0] rem [DW+1];
  logic [DW-1:0] qd  [DW+1];
  logic [MW-1:0] dd  [DW+1];
  logic          ng  [DW+1];

  logic signed [DW:0]      abs_n;
  logic signed [DEN_W-1:0] abs_d;

  always_comb begin
    abs_n = num[DW] ? -num : num;
    abs_d = den[DEN_W-1] ? -den : den;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      qd[0]  <= abs_n[DW-1:0];
      dd[0]  <= abs_d[MW-1:0];
      ng[0]  <= num[DW] ^ den[DEN_W-1];
    end
  end

  for (genvar k = 1; k <= DW; k++) begin : g_stage
    logic [MW:0] z;
    logic        ge;
    assign z  = {rem[k-1], qd[k-1][DW-1]};
    assign ge = z >= {1'b0, dd[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? MW'(z - {1'b0, dd[k-1]}) : z[MW-1:0];
        qd[k]  <= {qd[k-1][DW-2:0], ge};
        dd[k]  <= dd[k-1];
        ng[k]  <= ng[k-1];
      end
    end
  end

  // negative floor: -q - 1 when a remainder is left, else -q
  always_ff @(posedge clk) begin
    if (en) begin
      q <= ng[DW] ? ~{1'b0, qd[DW]} + NW'(rem[DW] == '0) : {1'b0, qd[DW]};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/csd_pre.sv
// ----------------------------------------------------------------------------
// Collision safe distance front end
// Input products, scaled dividends and divisors for the divider bank.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_pre #(
  parameter int FRAC_BITS = 8,
  parameter int DW = 29
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [14:0]               front_speed,
  input  logic signed [14:0]               rear_speed,
  input  logic signed [12:0]               front_accel,
  input  logic signed [12:0]               rear_accel,
  input  logic [11:0]                      reaction_time,
  output logic                             out_valid,
  output csd_pkg::side_t                   side,
  output logic signed [DW:0]               n1,
  output logic signed [DW:0]               n2,
  output logic signed [DW:0]               n3,
  output logic signed [DW:0]               n4,
  output logic signed [DW:0]               n5,
  output logic signed [DW:0]               n6,
  output logic signed [DW:0]               n7,
  output logic signed [csd_pkg::DEN_W-1:0] d1,
  output logic signed [csd_pkg::DEN_W-1:0] d4,
  output logic signed [csd_pkg::DEN_W-1:0] d5,
  output logic signed [csd_pkg::DEN_W-1:0] d7
);

  import csd_pkg::*;

  localparam int NW = DW + 1;

  logic                s1_valid;
  logic signed [14:0]  v0;
  logic signed [14:0]  v1;
  logic signed [12:0]  a0;
  logic signed [12:0]  a1;
  logic signed [29:0]  pvv;
  logic signed [29:0]  p01;
  logic signed [29:0]  p00;
  logic signed [25:0]  pta;
  logic signed [12:0]  t13;

  logic signed [15:0]            dv;
  logic signed [25-FRAC_BITS:0]  mta;
  logic signed [DW:0]            num;

  assign t13 = signed'({1'b0, reaction_time});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v0  <= front_speed;
      v1  <= rear_speed;
      a0  <= front_accel;
      a1  <= rear_accel;
      pvv <= 30'(rear_speed) * 30'(rear_speed);
      p01 <= 30'(front_speed) * 30'(rear_speed);
      p00 <= 30'(front_speed) * 30'(front_speed);
      pta <= 26'(t13) * 26'(front_accel);
    end
  end

  always_comb begin
    dv  = 16'(v1) - 16'(v0);
    mta = $signed(pta[25:FRAC_BITS]);
    num = NW'(dv) - NW'(mta);
  end

  // floor then rescale is a clear of the fraction bits
  always_ff @(posedge clk) begin
    if (en) begin
      n1 <= NW'(v1) <<< FRAC_BITS;
      n2 <= NW'($signed({pvv[29:FRAC_BITS], {FRAC_BITS{1'b0}}}));
      n3 <= NW'($signed({p01[29:FRAC_BITS], {FRAC_BITS{1'b0}}}));
      n4 <= NW'(dv) <<< FRAC_BITS;
      n5 <= NW'(v0) <<< FRAC_BITS;
      n6 <= NW'($signed({p00[29:FRAC_BITS], {FRAC_BITS{1'b0}}}));
      n7 <= num <<< FRAC_BITS;
      d1 <= -(DEN_W'(a1));
      d4 <= DEN_W'(a0);
      d5 <= -(DEN_W'(a0));
      d7 <= DEN_W'(a0) - DEN_W'(a1);
      side <= '{dv: dv, v1: v1, a0: a0, a1: a1,
                v0_neg: v0[14],
                a0_pos: !a0[12] && (a0 != '0),
                a0_zero: a0 == '0,
                a1_zero: a1 == '0,
                den_zero: a0 == a1};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/csd_post.sv
// ----------------------------------------------------------------------------
// Collision safe distance back end
// Case selection, distance products and sums, output clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_post #(
  parameter int FRAC_BITS = 8,
  parameter int DW = 29
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  csd_pkg::side_t     side,
  input  logic signed [DW:0] q1,
  input  logic signed [DW:0] q2,
  input  logic signed [DW:0] q3,
  input  logic signed [DW:0] q4,
  input  logic signed [DW:0] q5,
  input  logic signed [DW:0] q6,
  input  logic signed [DW:0] q7,
  input  logic [11:0]        reaction_time,
  input  logic [14:0]        min_gap,
  output logic               out_valid,
  output logic signed [23:0] safe_distance,
  output logic [2:0]         case_code,
  output logic               saturated
);

  import csd_pkg::*;

  localparam int QW   = DW + 1;
  localparam int SQW  = QW + 1;
  localparam int PBW  = 13 + QW;
  localparam int MBW  = PBW - FRAC_BITS;
  localparam int PB2W = MBW + QW;
  localparam int MB2W = PB2W - FRAC_BITS;
  localparam int MCW  = 26 - FRAC_BITS;
  localparam int PC2W = MCW + 13;
  localparam int MC2W = PC2W - FRAC_BITS;
  localparam int MDW  = 26 - FRAC_BITS;
  localparam int PD2W = MDW + QW;
  localparam int MD2W = PD2W - FRAC_BITS;
  localparam int PEW  = 13 + QW;
  localparam int MEW  = PEW - FRAC_BITS;
  localparam int PE2W = MEW + QW;
  localparam int ME2W = PE2W - FRAC_BITS;
  localparam int PFW  = 13 + SQW;
  localparam int MFW  = PFW - FRAC_BITS;
  localparam int PF2W = MFW + SQW;
  localparam int MF2W = PF2W - FRAC_BITS;
  localparam int MAW  = 29 - FRAC_BITS;
  localparam int MGW  = 28 - FRAC_BITS;
  localparam int SW   = MF2W + 4;

  localparam logic signed [SW-1:0] FAR_VAL = SW'(1000) <<< FRAC_BITS;

  logic signed [12:0] t13;
  logic signed [15:0] d0s;

  assign t13 = signed'({1'b0, reaction_time});
  assign d0s = signed'({1'b0, min_gap});

  // stage 1: dispatch and first products
  logic [2:0]          code_next;
  logic                dz_next;
  logic [2:0]          rear_code;
  logic signed [QW:0]  rst_sum;

  always_comb begin
    rear_code = (!side.den_zero && q7[QW-1]) ? CODE_NOEQ : CODE_REAR;
    rst_sum   = SQW'(q1) + SQW'(t13);
    code_next = rear_code;
    dz_next   = side.den_zero;
    if (side.v0_neg) begin
      code_next = CODE_ONCOMING;
      dz_next   = side.a1_zero;
    end else if (side.a0_pos) begin
      if (q4[QW-1]) begin
        code_next = CODE_AWAY;
        dz_next   = 1'b0;
      end else if (q4 < QW'(t13)) begin
        code_next = CODE_REACT;
        dz_next   = 1'b0;
      end
    end else if (!side.a0_zero) begin
      if (side.a1_zero) begin
        code_next = CODE_FRONT;
        dz_next   = 1'b1;
      end else if (SQW'(q5) < rst_sum) begin
        code_next = CODE_FRONT;
        dz_next   = 1'b0;
      end
    end
  end

  logic                 s1_valid;
  logic [2:0]           s1_code;
  logic                 s1_dz;
  logic signed [28:0]   pa;
  logic signed [PBW-1:0] pb;
  logic signed [25:0]   pc;
  logic signed [25:0]   pd;
  logic signed [PEW-1:0] pe;
  logic signed [27:0]   pg;
  logic signed [SQW-1:0] s1_s;
  logic signed [QW-1:0] s1_r;
  logic signed [QW-1:0] s1_et;
  logic signed [QW-1:0] s1_q2;
  logic signed [QW-1:0] s1_q3;
  logic signed [QW-1:0] s1_q6;
  logic signed [12:0]   s1_a0;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_code <= code_next;
      s1_dz   <= dz_next;
      pa      <= 29'(t13) * 29'(side.dv);
      pb      <= PBW'(side.a0) * PBW'(q1);
      pc      <= 26'(side.a0) * 26'(t13);
      pd      <= 26'(side.a1) * 26'(t13);
      pe      <= PEW'(side.a1) * PEW'(q7);
      pg      <= 28'(t13) * 28'(side.v1);
      s1_s    <= SQW'(q7) + SQW'(t13);
      s1_r    <= q1;
      s1_et   <= q7;
      s1_q2   <= q2;
      s1_q3   <= q3;
      s1_q6   <= q6;
      s1_a0   <= side.a0;
    end
  end

  // stage 2: second products
  logic signed [MBW-1:0] mb;
  logic signed [MCW-1:0] mc;
  logic signed [MDW-1:0] md;
  logic signed [MEW-1:0] me;

  always_comb begin
    mb = $signed(pb[PBW-1:FRAC_BITS]);
    mc = $signed(pc[25:FRAC_BITS]);
    md = $signed(pd[25:FRAC_BITS]);
    me = $signed(pe[PEW-1:FRAC_BITS]);
  end

  logic                   s2_valid;
  logic [2:0]             s2_code;
  logic                   s2_dz;
  logic signed [PB2W-1:0] pb2;
  logic signed [PC2W-1:0] pc2;
  logic signed [PD2W-1:0] pd2;
  logic signed [PE2W-1:0] pe2;
  logic signed [PFW-1:0]  pf;
  logic signed [SQW-1:0]  s2_s;
  logic signed [MAW-1:0]  s2_ma;
  logic signed [MGW-1:0]  s2_mg;
  logic signed [QW-1:0]   s2_q2;
  logic signed [QW-1:0]   s2_q3;
  logic signed [QW-1:0]   s2_q6;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_code <= s1_code;
      s2_dz   <= s1_dz;
      pb2     <= PB2W'(mb) * PB2W'(s1_r);
      pc2     <= PC2W'(mc) * PC2W'(t13);
      pd2     <= PD2W'(md) * PD2W'(s1_et);
      pe2     <= PE2W'(me) * PE2W'(s1_et);
      pf      <= PFW'(s1_a0) * PFW'(s1_s);
      s2_s    <= s1_s;
      s2_ma   <= $signed(pa[28:FRAC_BITS]);
      s2_mg   <= $signed(pg[27:FRAC_BITS]);
      s2_q2   <= s1_q2;
      s2_q3   <= s1_q3;
      s2_q6   <= s1_q6;
    end
  end

  // stage 3: last product and partial sums
  logic signed [MFW-1:0]  mf;
  logic signed [MB2W-1:0] mb2;
  logic signed [MC2W-1:0] mc2;
  logic signed [MD2W-1:0] md2;
  logic signed [ME2W-1:0] me2;

  always_comb begin
    mf  = $signed(pf[PFW-1:FRAC_BITS]);
    mb2 = $signed(pb2[PB2W-1:FRAC_BITS]);
    mc2 = $signed(pc2[PC2W-1:FRAC_BITS]);
    md2 = $signed(pd2[PD2W-1:FRAC_BITS]);
    me2 = $signed(pe2[PE2W-1:FRAC_BITS]);
  end

  logic                   s3_valid;
  logic [2:0]             s3_code;
  logic                   s3_dz;
  logic signed [PF2W-1:0] pf2;
  logic signed [SW-1:0]   c0a;
  logic signed [SW-1:0]   c0b;
  logic signed [SW-1:0]   c1;
  logic signed [SW-1:0]   c2a;
  logic signed [SW-1:0]   c3a;
  logic signed [SW-1:0]   c3b;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_code <= s2_code;
      s3_dz   <= s2_dz;
      pf2     <= PF2W'(mf) * PF2W'(s2_s);
      c0a     <= SW'(s2_ma) + (SW'(s2_q2) >>> 1);
      c0b     <= SW'(d0s) - SW'(s2_q3) - (SW'(mb2) >>> 1);
      c1      <= SW'(s2_ma) - (SW'(mc2) >>> 1) + SW'(d0s);
      c2a     <= SW'(d0s) - SW'(md2) - (SW'(me2) >>> 1);
      c3a     <= SW'(s2_mg) + (SW'(s2_q2) >>> 1);
      c3b     <= SW'(d0s) - (SW'(s2_q6) >>> 1);
    end
  end

  // stage 4: final sums and case select
  logic signed [MF2W-1:0] mf2;
  logic signed [SW-1:0]   sel_next;

  assign mf2 = $signed(pf2[PF2W-1:FRAC_BITS]);

  always_comb begin
    case (s3_code) inside
      CODE_ONCOMING:        sel_next = c0a + c0b;
      CODE_REACT:           sel_next = c1;
      CODE_REAR:            sel_next = c2a + (SW'(mf2) >>> 1);
      CODE_FRONT:           sel_next = c3a + c3b;
      CODE_AWAY, CODE_NOEQ: sel_next = FAR_VAL;
      default:              sel_next = '0;
    endcase
  end

  logic                 s4_valid;
  logic [2:0]           s4_code;
  logic                 s4_dz;
  logic signed [SW-1:0] sel;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_code <= s3_code;
      s4_dz   <= s3_dz;
      sel     <= sel_next;
    end
  end

  // stage 5: clamp into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      case_code <= s4_code;
      if (s4_dz || sel > SW'(DIST_MAX)) begin
        safe_distance <= DIST_MAX;
        saturated     <= 1'b1;
      end else if (sel < SW'(DIST_MIN)) begin
        safe_distance <= DIST_MIN;
        saturated     <= 1'b1;
      end else begin
        safe_distance <= sel[23:0];
        saturated     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/collision_safe_distance_core.sv
// ----------------------------------------------------------------------------
// Collision safe distance core
// DW = max(29, FRAC_BITS + 17); the depth is set by the seven restoring dividers,
// one quotient bit per stage, running side by side. Throughput: one transaction
// per cycle unless the output stalls waiting on m_axis_tready.
// Reset clears all valid bits and loads reaction_time 563 and min_gap 512.
// ----------------------------------------------------------------------------
`default_nettype none
`include "collision_safe_distance_core_macros.svh"

module collision_safe_distance_core #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // front_speed[14:0], rear_speed[29:15], front_accel[42:30], rear_accel[55:43]
  input  logic [55:0]                         s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // safe_distance[23:0]
  output logic [23:0]                         m_axis_tdata,
  // case_code[2:0], saturated[3]
  output logic [3:0]                          m_axis_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csd_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [csd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import csd_pkg::*;

  localparam int DW  = (FRAC_BITS + 17 > 29) ? FRAC_BITS + 17 : 29;
  localparam int LAT = DW + 9;
  localparam int OCW = $clog2(LAT + 1) + 1;
  localparam int SIDE_W = $bits(side_t);
  localparam int FAR_RAW = 1000 * (2 ** FRAC_BITS);
  localparam bit FAR_BIG = FAR_RAW > 8388607;
  localparam logic [23:0] FAR_DIST = FAR_BIG ? 24'h7FFFFF : 24'(FAR_RAW);

  logic        en;
  logic [11:0] reaction_time;
  logic [14:0] min_gap;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reaction_time <= RT_RESET;
      min_gap       <= MG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_REACTION: reaction_time <= cfg_data[11:0];
        REG_MIN_GAP:  min_gap       <= cfg_data;
      endcase
    end
  end

  logic                    pre_valid;
  side_t                   pre_side;
  logic signed [DW:0]      n1, n2, n3, n4, n5, n6, n7;
  logic signed [DEN_W-1:0] d1, d4, d5, d7;

  csd_pre #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_pre (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (s_axis_tvalid),
    .front_speed  ($signed(s_axis_tdata[14:0])),
    .rear_speed   ($signed(s_axis_tdata[29:15])),
    .front_accel  ($signed(s_axis_tdata[42:30])),
    .rear_accel   ($signed(s_axis_tdata[55:43])),
    .reaction_time(reaction_time),
    .out_valid    (pre_valid),
    .side         (pre_side),
    .n1(n1), .n2(n2), .n3(n3), .n4(n4), .n5(n5), .n6(n6), .n7(n7),
    .d1(d1), .d4(d4), .d5(d5), .d7(d7)
  );

  logic signed [DW:0] q1, q2, q3, q4, q5, q6, q7;

  csd_div #(.DW(DW)) u_div_r   (.clk(clk), .en(en), .num(n1), .den(d1), .q(q1));
  csd_div #(.DW(DW)) u_div_vv  (.clk(clk), .en(en), .num(n2), .den(d1), .q(q2));
  csd_div #(.DW(DW)) u_div_v01 (.clk(clk), .en(en), .num(n3), .den(d1), .q(q3));
  csd_div #(.DW(DW)) u_div_st  (.clk(clk), .en(en), .num(n4), .den(d4), .q(q4));
  csd_div #(.DW(DW)) u_div_fst (.clk(clk), .en(en), .num(n5), .den(d5), .q(q5));
  csd_div #(.DW(DW)) u_div_v00 (.clk(clk), .en(en), .num(n6), .den(d5), .q(q6));
  csd_div #(.DW(DW)) u_div_et  (.clk(clk), .en(en), .num(n7), .den(d7), .q(q7));

  logic              dly_valid;
  logic [SIDE_W-1:0] dly_data;

  csd_delay #(.W(SIDE_W), .DEPTH(DW + 2)) u_delay (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (pre_valid),
    .in_data  (pre_side),
    .out_valid(dly_valid),
    .out_data (dly_data)
  );

  logic signed [23:0] out_dist;
  logic [2:0]         out_code;
  logic               out_sat;

  csd_post #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_post (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (dly_valid),
    .side         (side_t'(dly_data)),
    .q1(q1), .q2(q2), .q3(q3), .q4(q4), .q5(q5), .q6(q6), .q7(q7),
    .reaction_time(reaction_time),
    .min_gap      (min_gap),
    .out_valid    (m_axis_tvalid),
    .safe_distance(out_dist),
    .case_code    (out_code),
    .saturated    (out_sat)
  );

  assign m_axis_tdata = out_dist;
  assign m_axis_tuser = {out_sat, out_code};

  // transactions in flight
  logic           in_acc;
  logic           out_acc;
  logic [OCW-1:0] occ;
  logic           far_out;
  logic           far_ok;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign far_out = m_axis_tvalid && (out_code == CODE_AWAY || out_code == CODE_NOEQ);
  assign far_ok  = (m_axis_tdata == FAR_DIST) && (out_sat == FAR_BIG);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCW'(in_acc) - OCW'(out_acc);
    end
  end

  `CSD_ASSERT_IMPLY(a_occ_bound, 1'b1, occ <= OCW'(LAT), "more transactions than stages")
  `CSD_ASSERT_IMPLY(a_far_value, far_out, far_ok, "far case distance wrong")
  `CSD_ASSERT_NEXT(a_no_phantom, occ == '0 && !in_acc, !m_axis_tvalid, "output valid with empty pipe")

endmodule

`default_nettype wire
